/* rtl/core/wsbp_pkg.sv */
// Shared constants, codes and command/status types of the single-bin power core.
`timescale 1ns / 1ps

package wsbp_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int POS_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = POS_W + 1;

  localparam int OP_W       = 1;
  localparam int IDX_W      = 8;
  localparam int COEF_W     = 18;
  localparam int SMP_W      = 16;
  localparam int PROD_W     = COEF_W + SMP_W;
  localparam int ACC_W      = 42;
  localparam int SHIFT_W    = 6;
  localparam int WLEN_W     = 9;
  localparam int SAT_W      = 32;
  localparam int POWER_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int CMP_W      = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
  localparam int MAX_SHIFT  = ACC_W - 1;

  localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(256);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(8);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_RESULT_SHIFT  = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic ram_wr;
    logic smp_load;
    logic mac;
    logic shape;
    logic square;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

/* rtl/core/windowed_single_bin_power_core.sv */
// A load item writes the table; a sample item reads the table, then multiply-accumulates.
// A window's last sample goes on through MAC, shift/saturate, square and sum into the output
// register, which raises the result valid; the sum step waits while the result is stalled.
// The result register frees the input side; a new window's result waits only on it.
// Synchronous active-low reset clears control, accumulators, position and config
// (window length 256, shift 8); coefficient table contents are undefined until loaded.
`timescale 1ns / 1ps

module windowed_single_bin_power_core
  import wsbp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [IDX_W-1:0]         in_coef_index,
  input  logic signed [COEF_W-1:0] in_sine_coef,
  input  logic signed [COEF_W-1:0] in_cosine_coef,
  input  logic signed [SMP_W-1:0]  in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [POWER_W-1:0]       out_power,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  wsbp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation[0]),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status)
  );

  wsbp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_coef_index  (in_coef_index),
    .in_sine_coef   (in_sine_coef),
    .in_cosine_coef (in_cosine_coef),
    .in_sample      (in_sample),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_power      (out_power)
  );

endmodule

/* rtl/core/wsbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wsbp_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/wsbp_ctrl.sv */
// Sequencer for load, accumulate, shape, square and result transfer.
`timescale 1ns / 1ps

module wsbp_ctrl
  import wsbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_operation,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MAC    = 5'b00010,
    ST_SHAPE  = 5'b00100,
    ST_SQUARE = 5'b01000,
    ST_SUM    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_operation == OP_SAMPLE) begin
            cmd.smp_load = 1'b1;
            state_nxt    = ST_MAC;
          end else begin
            cmd.ram_wr = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cmd.mac   = 1'b1;
        state_nxt = status.last ? ST_SHAPE : ST_IDLE;
      end
      ST_SHAPE: begin
        cmd.shape = 1'b1;
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        // hold until the output register is free or being emptied
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  a_sample_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_operation == OP_SAMPLE) |=> state_r == ST_MAC)
    else $error("sample transfer did not start accumulation");

  a_mid_window_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC && !status.last) |=> (state_r == ST_IDLE && !cmd.out_load))
    else $error("mid-window sample did not return to idle");

  a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_SUM)
    else $error("result raised outside the summing step");
`endif

endmodule

/* rtl/core/wsbp_dp.sv */
// Datapath: coefficient RAM, MAC accumulators, shift/saturate, squares and result register.
`timescale 1ns / 1ps

module wsbp_dp
  import wsbp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic [IDX_W-1:0]          in_coef_index,
  input  logic signed [COEF_W-1:0]  in_sine_coef,
  input  logic signed [COEF_W-1:0]  in_cosine_coef,
  input  logic signed [SMP_W-1:0]   in_sample,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output logic [POWER_W-1:0]        out_power
);

  logic [WLEN_W-1:0]          wlen_r;
  logic [SHIFT_W-1:0]         shift_r;
  logic [POS_W-1:0]           pos_r;
  logic signed [SMP_W-1:0]    smp_r;
  logic signed [ACC_W-1:0]    acc_s_r, acc_c_r;
  logic signed [SAT_W-1:0]    sat_s_r, sat_c_r;
  logic [POWER_W-1:0]         sq_s_r, sq_c_r;
  logic [POWER_W-1:0]         power_r;

  logic [2*COEF_W-1:0]        rd_data;
  logic signed [COEF_W-1:0]   coef_s, coef_c;
  logic                       load_ok;
  logic [CMP_W-1:0]           len_m1;
  logic                       last;
  logic                       edge_pos;
  logic signed [PROD_W-1:0]   prod_s, prod_c;
  logic [SHIFT_W-1:0]         sh;
  logic signed [ACC_W-1:0]    shd_s, shd_c;

  // coefficient table, sine in the upper half
  assign load_ok = (32'(in_coef_index) < MAX_WINDOW);

  wsbp_ram #(
    .WIDTH (2*COEF_W),
    .DEPTH (MAX_WINDOW)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (cmd.ram_wr && load_ok),
    .wr_addr (POS_W'(in_coef_index)),
    .wr_data ({in_sine_coef, in_cosine_coef}),
    .rd_en   (cmd.smp_load),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign coef_s = rd_data[2*COEF_W-1:COEF_W];
  assign coef_c = rd_data[COEF_W-1:0];

  // clamp the window length to 2..MAX_WINDOW
  always_comb begin
    if (CMP_W'(wlen_r) < CMP_W'(2)) begin
      len_m1 = CMP_W'(1);
    end else if (CMP_W'(wlen_r) > CMP_W'(MAX_WINDOW)) begin
      len_m1 = CMP_W'(MAX_WINDOW - 1);
    end else begin
      len_m1 = CMP_W'(wlen_r) - CMP_W'(1);
    end
  end

  assign last        = (CMP_W'(pos_r) >= len_m1);
  assign edge_pos    = last || (pos_r == '0);
  assign status.last = last;

  // first and last products are halved, rounding to minus infinity
  always_comb begin
    prod_s = PROD_W'(smp_r * coef_s);
    prod_c = PROD_W'(smp_r * coef_c);
    if (edge_pos) begin
      prod_s = prod_s >>> 1;
      prod_c = prod_c >>> 1;
    end
  end

  assign sh    = (shift_r > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : shift_r;
  assign shd_s = acc_s_r >>> sh;
  assign shd_c = acc_c_r >>> sh;

  function automatic logic signed [SAT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-SAT_W:0] top;
    top = v[ACC_W-1:SAT_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[SAT_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAT_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WLEN_RESET;
      shift_r <= SHIFT_RESET;
      pos_r   <= '0;
      acc_s_r <= '0;
      acc_c_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WINDOW_LENGTH: wlen_r  <= WLEN_W'(cfg_data);
          CFG_RESULT_SHIFT:  shift_r <= cfg_data[SHIFT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.mac) begin
        acc_s_r <= acc_s_r + ACC_W'(prod_s);
        acc_c_r <= acc_c_r + ACC_W'(prod_c);
        pos_r   <= last ? '0 : pos_r + POS_W'(1);
      end
      if (cmd.shape) begin
        acc_s_r <= '0;
        acc_c_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_load) begin
      smp_r <= in_sample;
    end
    if (cmd.shape) begin
      sat_s_r <= sat32(shd_s);
      sat_c_r <= sat32(shd_c);
    end
    if (cmd.square) begin
      sq_s_r <= POWER_W'(sat_s_r * sat_s_r);
      sq_c_r <= POWER_W'(sat_c_r * sat_c_r);
    end
    if (cmd.out_load) begin
      power_r <= sq_s_r + sq_c_r;
    end
  end

  assign out_power = power_r;

endmodule
